// ===== rtl/core/smrms_pkg.sv =====
// Package for the smoothed RMS level meter: widths, constants and the
// sequencer state type. Used by the channel interfaces and the top level.
package smrms_pkg;

  localparam int unsigned FRAME_PAIRS = 256;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned MAG_W    = 15;
  localparam int unsigned WEIGHT_W = 9;
  localparam int unsigned RMS_W    = 15;
  localparam int unsigned LEVEL_W  = 22;
  localparam int unsigned SMOOTH_W = 23;
  localparam int unsigned SUM_W    = 38;
  localparam int unsigned ROOT_W   = 32;

  localparam int unsigned CNT_W  = $clog2(FRAME_PAIRS + 1);
  localparam int unsigned REM_W  = $clog2(2 * FRAME_PAIRS);
  localparam int unsigned DIV_W  = REM_W + 1;
  localparam int unsigned STEP_W = $clog2(SUM_W);

  localparam int unsigned MUL_A_W = MAG_W;
  localparam int unsigned MUL_B_W = SMOOTH_W;
  localparam int unsigned MUL_W   = MUL_A_W + MUL_B_W;

  localparam logic [WEIGHT_W-1:0] KEEP_WEIGHT_RST = WEIGHT_W'(154);
  localparam logic [WEIGHT_W-1:0] WEIGHT_FULL     = WEIGHT_W'(256);
  localparam logic [LEVEL_W-1:0]  LEVEL_MAX       = '1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [RMS_W-1:0]           rms_t;
  typedef logic [LEVEL_W-1:0]         level_t;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_SQL  = 10'b00_0000_0010,
    ST_SQR  = 10'b00_0000_0100,
    ST_ACC  = 10'b00_0000_1000,
    ST_DIV  = 10'b00_0001_0000,
    ST_SQRT = 10'b00_0010_0000,
    ST_MW   = 10'b00_0100_0000,
    ST_MR   = 10'b00_1000_0000,
    ST_MS   = 10'b01_0000_0000,
    ST_OUT  = 10'b10_0000_0000
  } state_e;

endpackage

// ===== rtl/core/smrms_in_if.sv =====
// Input channel of the level meter: one stereo sample pair per request.
// Depends on smrms_pkg for the sample type.
interface smrms_in_if;
  logic              valid;
  logic              ready;
  smrms_pkg::sample_t left_sample;
  smrms_pkg::sample_t right_sample;
  logic              last_in_frame;

  modport source (output valid, left_sample, right_sample, last_in_frame, input ready);
  modport sink   (input valid, left_sample, right_sample, last_in_frame, output ready);
endinterface

// ===== rtl/core/smrms_out_if.sv =====
// Output channel of the level meter: frame RMS and smoothed level.
// Depends on smrms_pkg for the field types.
interface smrms_out_if;
  logic              valid;
  logic              ready;
  smrms_pkg::rms_t   rms_level;
  smrms_pkg::level_t smoothed_level;

  modport source (output valid, rms_level, smoothed_level, input ready);
  modport sink   (input valid, rms_level, smoothed_level, output ready);
endinterface

// ===== rtl/core/smoothed_rms_level_meter_top.sv =====
// Smoothed RMS level meter, top level. Depends on smrms_pkg and the two channel interfaces.
// Sequence: a sample pair that does not end a frame passes through accept, two squares
// on the shared multiplier and accumulate. A frame-ending pair adds 38 divider steps,
// 16 square-root steps and the smoothing states MW, MR and MS before its result is offered.
// Reset (rst_ni low, asynchronous) clears the sum, pair count and smoothed level and
// sets keep_weight to 154.
module smoothed_rms_level_meter_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  smrms_in_if.sink                       req_i,
  smrms_out_if.source                    res_o,
  input  logic                           cfg_we_i,
  input  logic [smrms_pkg::WEIGHT_W-1:0] cfg_wdata_i
);

  smrms_pkg::state_e state_q, state_d;

  // Configuration register.
  logic [smrms_pkg::WEIGHT_W-1:0] kw_q;

  // Halved sample magnitudes and the frame mark of the request in progress.
  logic [smrms_pkg::MAG_W-1:0] lmag_q, rmag_q;
  logic                        last_q;

  // Running sum; it also serves as dividend and quotient shift register during the
  // division and as the holding register for the old-level product during smoothing.
  logic [smrms_pkg::SUM_W-1:0]   sum_q, sum_d;
  logic [smrms_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [smrms_pkg::MUL_W-1:0]   prod_q;
  logic [smrms_pkg::DIV_W-1:0]   dvsr_q, dvsr_d;
  logic [smrms_pkg::REM_W-1:0]   rem_q, rem_d;
  logic [smrms_pkg::STEP_W-1:0]  step_q, step_d;
  logic [smrms_pkg::ROOT_W-1:0]  x_q, x_d, root_q, root_d, bit_q, bit_d;
  logic [smrms_pkg::SMOOTH_W-1:0] smooth_q, smooth_d;

  logic                               out_valid_q, out_valid_d;
  logic [smrms_pkg::RMS_W-1:0]        out_rms_q;
  logic [smrms_pkg::LEVEL_W-1:0]      out_lvl_q;
  logic                               out_load;

  // Shared multiplier and its operand selection.
  logic [smrms_pkg::MUL_A_W-1:0] mul_a;
  logic [smrms_pkg::MUL_B_W-1:0] mul_b;
  logic [smrms_pkg::MUL_W-1:0]   mul_p;

  logic [smrms_pkg::WEIGHT_W-1:0] w_eff, w_new;
  logic [smrms_pkg::SUM_W:0]      sum_add;
  logic [smrms_pkg::SUM_W-1:0]    sum_sat;
  logic [smrms_pkg::CNT_W-1:0]    cnt_inc;
  logic                           frame_end;
  logic [smrms_pkg::DIV_W-1:0]    rem_sh;
  logic                           qbit;
  logic [smrms_pkg::SUM_W-1:0]    quot_next;
  logic [smrms_pkg::ROOT_W-1:0]   sq_trial;
  logic [smrms_pkg::SUM_W+1:0]    mix_sum;

  smrms_pkg::sample_t lhalf, rhalf, lneg, rneg;

  // Weights above 256 act as 256, which freezes the smoothed level.
  assign w_eff = (kw_q > smrms_pkg::WEIGHT_FULL) ? smrms_pkg::WEIGHT_FULL : kw_q;
  assign w_new = smrms_pkg::WEIGHT_FULL - w_eff;

  // Arithmetic halving; the magnitude of -16384 still fits in 15 bits.
  assign lhalf = req_i.left_sample >>> 1;
  assign rhalf = req_i.right_sample >>> 1;
  assign lneg  = -lhalf;
  assign rneg  = -rhalf;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      smrms_pkg::ST_SQL: begin
        mul_a = lmag_q;
        mul_b = smrms_pkg::MUL_B_W'(lmag_q);
      end
      smrms_pkg::ST_SQR: begin
        mul_a = rmag_q;
        mul_b = smrms_pkg::MUL_B_W'(rmag_q);
      end
      smrms_pkg::ST_MW: begin
        mul_a = smrms_pkg::MUL_A_W'(w_eff);
        mul_b = smooth_q;
      end
      smrms_pkg::ST_MR: begin
        mul_a = smrms_pkg::MUL_A_W'(w_new);
        mul_b = smrms_pkg::MUL_B_W'(root_q[smrms_pkg::RMS_W-1:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = smrms_pkg::MUL_W'(mul_a) * smrms_pkg::MUL_W'(mul_b);

  // Saturating accumulate of the registered square.
  assign sum_add = {1'b0, sum_q} + (smrms_pkg::SUM_W + 1)'(prod_q);
  assign sum_sat = sum_add[smrms_pkg::SUM_W] ? '1 : sum_add[smrms_pkg::SUM_W-1:0];

  // The pair count stops at the frame length; reaching it ends the frame on its own.
  assign cnt_inc   = (cnt_q < smrms_pkg::CNT_W'(smrms_pkg::FRAME_PAIRS)) ? cnt_q + 1'b1 : cnt_q;
  assign frame_end = last_q || (cnt_inc >= smrms_pkg::CNT_W'(smrms_pkg::FRAME_PAIRS));

  // One restoring division step: the sum divided by twice the pair count.
  assign rem_sh    = {rem_q, sum_q[smrms_pkg::SUM_W-1]};
  assign qbit      = (rem_sh >= dvsr_q);
  assign quot_next = {sum_q[smrms_pkg::SUM_W-2:0], qbit};

  // One digit of the integer square root.
  assign sq_trial = root_q + bit_q;

  // New level: (w * old + (256 - w) * (rms << 8)) >> 8, kept to 23 bits.
  assign mix_sum = (smrms_pkg::SUM_W + 2)'(sum_q) + ((smrms_pkg::SUM_W + 2)'(prod_q) << 8);

  assign out_load = (state_q == smrms_pkg::ST_OUT) && (!out_valid_q || res_o.ready);

  always_comb begin
    state_d  = state_q;
    sum_d    = sum_q;
    cnt_d    = cnt_q;
    dvsr_d   = dvsr_q;
    rem_d    = rem_q;
    step_d   = step_q;
    x_d      = x_q;
    root_d   = root_q;
    bit_d    = bit_q;
    smooth_d = smooth_q;
    case (state_q)
      smrms_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          state_d = smrms_pkg::ST_SQL;
        end
      end
      smrms_pkg::ST_SQL: begin
        state_d = smrms_pkg::ST_SQR;
      end
      smrms_pkg::ST_SQR: begin
        sum_d   = sum_sat;
        state_d = smrms_pkg::ST_ACC;
      end
      smrms_pkg::ST_ACC: begin
        sum_d  = sum_sat;
        cnt_d  = cnt_inc;
        dvsr_d = smrms_pkg::DIV_W'({cnt_inc, 1'b0});
        rem_d  = '0;
        step_d = '0;
        state_d = frame_end ? smrms_pkg::ST_DIV : smrms_pkg::ST_IDLE;
      end
      smrms_pkg::ST_DIV: begin
        sum_d  = quot_next;
        rem_d  = qbit ? smrms_pkg::REM_W'(rem_sh - dvsr_q) : smrms_pkg::REM_W'(rem_sh);
        step_d = step_q + 1'b1;
        if (step_q == smrms_pkg::STEP_W'(smrms_pkg::SUM_W - 1)) begin
          // The mean is clamped to 32 bits before the square root.
          x_d    = (quot_next[smrms_pkg::SUM_W-1:smrms_pkg::ROOT_W] != '0) ? '1 :
                   quot_next[smrms_pkg::ROOT_W-1:0];
          root_d = '0;
          bit_d  = smrms_pkg::ROOT_W'(1) << (smrms_pkg::ROOT_W - 2);
          state_d = smrms_pkg::ST_SQRT;
        end
      end
      smrms_pkg::ST_SQRT: begin
        if (x_q >= sq_trial) begin
          x_d    = x_q - sq_trial;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          state_d = smrms_pkg::ST_MW;
        end
      end
      smrms_pkg::ST_MW: begin
        state_d = smrms_pkg::ST_MR;
      end
      smrms_pkg::ST_MR: begin
        sum_d   = prod_q;
        state_d = smrms_pkg::ST_MS;
      end
      smrms_pkg::ST_MS: begin
        smooth_d = mix_sum[smrms_pkg::SMOOTH_W+7:8];
        state_d  = smrms_pkg::ST_OUT;
      end
      smrms_pkg::ST_OUT: begin
        if (out_load) begin
          sum_d   = '0;
          cnt_d   = '0;
          state_d = smrms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = smrms_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smrms_pkg::ST_IDLE;
      kw_q        <= smrms_pkg::KEEP_WEIGHT_RST;
      sum_q       <= '0;
      cnt_q       <= '0;
      smooth_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      smooth_q    <= smooth_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        kw_q <= cfg_wdata_i;
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    dvsr_q <= dvsr_d;
    rem_q  <= rem_d;
    step_q <= step_d;
    x_q    <= x_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    if (req_i.valid && req_i.ready) begin
      lmag_q <= lhalf[smrms_pkg::SAMPLE_W-1] ? lneg[smrms_pkg::MAG_W-1:0] :
                lhalf[smrms_pkg::MAG_W-1:0];
      rmag_q <= rhalf[smrms_pkg::SAMPLE_W-1] ? rneg[smrms_pkg::MAG_W-1:0] :
                rhalf[smrms_pkg::MAG_W-1:0];
      last_q <= req_i.last_in_frame;
    end
    if (out_load) begin
      out_rms_q <= root_q[smrms_pkg::RMS_W-1:0];
      out_lvl_q <= smooth_q[smrms_pkg::SMOOTH_W-1] ? smrms_pkg::LEVEL_MAX :
                   smooth_q[smrms_pkg::LEVEL_W-1:0];
    end
  end

  // A new pair is taken only between requests; a finished result may still wait.
  assign req_i.ready          = (state_q == smrms_pkg::ST_IDLE);
  assign res_o.valid          = out_valid_q;
  assign res_o.rms_level      = out_rms_q;
  assign res_o.smoothed_level = out_lvl_q;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the smoothed RMS level meter top level.
// Depends on smrms_pkg, smrms_in_if, smrms_out_if and smoothed_rms_level_meter_top.

module tb_top;

  // The run is cut off here if the meter stops making progress.
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  // A frame-ending request still has the division, the square root and the smoothing
  // to go after it is taken, so this pause covers any request still being worked on.
  localparam int unsigned DRAIN_CYCLES    = 80;
  localparam int unsigned PAIRS_PER_PHASE = 260;
  localparam int unsigned REPORT_LIMIT    = 10;
  localparam longint unsigned SUM_SAT     = (64'd1 << smrms_pkg::SUM_W) - 64'd1;

  typedef struct packed {
    smrms_pkg::rms_t   rms;
    smrms_pkg::level_t level;
  } meter_reading_t;

  typedef enum logic [1:0] {
    ROW_PAIR,
    ROW_WEIGHT
  } row_kind_e;

  // One row of the directed part. A pair row is sent reps times; typed rows
  // carry the result worked out by hand.
  typedef struct packed {
    row_kind_e kind;
    int        reps;
    int        weight;
    int        left;
    int        right;
    bit        last;
    bit        typed;
    int        rms;
    int        level;
  } stimulus_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [smrms_pkg::WEIGHT_W-1:0] cfg_wdata_i;

  smrms_in_if  req_if ();
  smrms_out_if res_if ();

  smoothed_rms_level_meter_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Shadow copy of the meter's state, kept in step with every accepted request.
  logic [smrms_pkg::SUM_W-1:0]    sum_of_squares_q;
  int unsigned                    pairs_in_frame_q;
  logic [smrms_pkg::SMOOTH_W-1:0] smoothed_q;
  logic [smrms_pkg::WEIGHT_W-1:0] keep_weight_q;

  // Results still owed by the meter, oldest first.
  meter_reading_t pending_readings[$];

  int unsigned mismatches;
  int unsigned accepted_pairs;
  int unsigned cycle_count;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  logic        stall_hold;

  // The directed rows walk through reset behavior, full-scale samples of both
  // signs, multi-pair frames, a frame that ends without its mark after the
  // full pair count, weight extremes (no smoothing, hold, weights above full
  // scale acting as full scale) and the saturation of the smoothed level.
  stimulus_row_t directed_rows [22] = '{
    '{ROW_PAIR,     1,   0,      0,      0, 1'b1, 1'b1,     0,       0},
    '{ROW_PAIR,     1,   0, -32768, -32768, 1'b1, 1'b1, 16384, 1671168},
    '{ROW_PAIR,     1,   0,  32767,  32767, 1'b1, 1'b0,     0,       0},
    '{ROW_PAIR,     1,   0,     -1,      1, 1'b0, 1'b0,     0,       0},
    '{ROW_PAIR,     1,   0,      1,     -1, 1'b0, 1'b0,     0,       0},
    '{ROW_PAIR,     1,   0, -32768,  32767, 1'b1, 1'b0,     0,       0},
    '{ROW_PAIR,   256,   0,   1000,  -1000, 1'b0, 1'b0,     0,       0},
    '{ROW_PAIR,     1,   0,  12345, -12345, 1'b1, 1'b0,     0,       0},
    '{ROW_WEIGHT,   0,   0,      0,      0, 1'b0, 1'b0,     0,       0},
    '{ROW_PAIR,     1,   0, -32768, -32768, 1'b1, 1'b1, 16384, 4194303},
    '{ROW_WEIGHT,   0, 256,      0,      0, 1'b0, 1'b0,     0,       0},
    '{ROW_PAIR,     1,   0,      0,      0, 1'b1, 1'b1,     0, 4194303},
    '{ROW_WEIGHT,   0, 511,      0,      0, 1'b0, 1'b0,     0,       0},
    '{ROW_PAIR,     1,   0,      5,      5, 1'b1, 1'b1,     2, 4194303},
    '{ROW_WEIGHT,   0,   0,      0,      0, 1'b0, 1'b0,     0,       0},
    '{ROW_PAIR,     1,   0,      0,      0, 1'b1, 1'b1,     0,       0},
    '{ROW_WEIGHT,   0, 154,      0,      0, 1'b0, 1'b0,     0,       0},
    '{ROW_PAIR,     1,   0,     -3,      7, 1'b1, 1'b0,     0,       0},
    '{ROW_PAIR,     2,   0,  32767, -32768, 1'b0, 1'b0,     0,       0},
    '{ROW_PAIR,     1,   0,      0,      0, 1'b1, 1'b0,     0,       0},
    '{ROW_PAIR,     3,   0,    -12,  21845, 1'b0, 1'b0,     0,       0},
    '{ROW_PAIR,     1,   0, -21846,  10922, 1'b1, 1'b0,     0,       0}
  };

  // 10 ns clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Floor square root, one result bit per pass.
  function automatic logic [31:0] floor_sqrt(input logic [31:0] value);
    logic [31:0] rest;
    logic [31:0] root;
    logic [31:0] probe;
    rest  = value;
    root  = '0;
    probe = 32'h4000_0000;
    while (probe > rest) probe = probe >> 2;
    while (probe != 0) begin
      if (rest >= root + probe) begin
        rest = rest - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // Adds one halved sample pair to the frame and, when the frame closes,
  // works out the frame RMS and the new smoothed level.
  function automatic bit accumulate_pair(input smrms_pkg::sample_t left,
                                         input smrms_pkg::sample_t right,
                                         input logic last, output meter_reading_t reading);
    smrms_pkg::sample_t     half_l;
    smrms_pkg::sample_t     half_r;
    longint                 lv;
    longint                 rv;
    longint unsigned        total;
    longint unsigned        mean;
    longint unsigned        w;
    longint unsigned        blended;
    logic [31:0]            root;
    half_l  = left >>> 1;
    half_r  = right >>> 1;
    lv      = half_l;
    rv      = half_r;
    reading = '0;
    total   = longint'(sum_of_squares_q) + longint'(lv * lv + rv * rv);
    sum_of_squares_q = (total > SUM_SAT) ? SUM_SAT[smrms_pkg::SUM_W-1:0] :
                       total[smrms_pkg::SUM_W-1:0];
    if (pairs_in_frame_q < smrms_pkg::FRAME_PAIRS) pairs_in_frame_q++;
    if (!last && pairs_in_frame_q < smrms_pkg::FRAME_PAIRS) return 1'b0;

    mean = longint'(sum_of_squares_q) / (2 * pairs_in_frame_q);
    if (mean > 64'hFFFF_FFFF) mean = 64'hFFFF_FFFF;
    root = floor_sqrt(mean[31:0]);

    // Weights above full scale behave as full scale: the level holds.
    w = (keep_weight_q > smrms_pkg::WEIGHT_FULL) ? 256 : keep_weight_q;
    blended = (w * smoothed_q + (256 - w) * (longint'(root) << 8)) >> 8;
    smoothed_q = blended[smrms_pkg::SMOOTH_W-1:0];

    reading.rms   = root[smrms_pkg::RMS_W-1:0];
    reading.level = (smoothed_q > smrms_pkg::LEVEL_MAX) ? smrms_pkg::LEVEL_MAX :
                    smoothed_q[smrms_pkg::LEVEL_W-1:0];
    sum_of_squares_q = '0;
    pairs_in_frame_q = 0;
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // Offers one sample pair, with random idle cycles first when the phase asks
  // for them, and records the owed result once the request is taken.
  task automatic send_pair(input smrms_pkg::sample_t left, input smrms_pkg::sample_t right,
                           input logic last, input bit typed,
                           input smrms_pkg::rms_t typed_rms,
                           input smrms_pkg::level_t typed_level);
    meter_reading_t reading;
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.left_sample   <= left;
    req_if.right_sample  <= right;
    req_if.last_in_frame <= last;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    accepted_pairs++;
    if (accumulate_pair(left, right, last, reading)) begin
      if (typed) begin
        reading.rms   = typed_rms;
        reading.level = typed_level;
      end
      pending_readings.push_back(reading);
    end
  endtask

  // The weight is only changed once the meter has delivered everything and
  // had time to finish any pair still in its pipeline.
  task automatic write_keep_weight(input logic [smrms_pkg::WEIGHT_W-1:0] value);
    req_if.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    keep_weight_q = value;
    cfg_we_i <= 1'b0;
  endtask

  // Mostly full-range samples, with extremes and near-silence mixed in.
  function automatic smrms_pkg::sample_t pick_sample();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 10) begin
      case ($urandom_range(4))
        0: return smrms_pkg::sample_t'(-32768);
        1: return smrms_pkg::sample_t'(32767);
        2: return smrms_pkg::sample_t'(-1);
        3: return smrms_pkg::sample_t'(1);
        default: return smrms_pkg::sample_t'(0);
      endcase
    end
    if (sel < 25) return smrms_pkg::sample_t'(int'($urandom_range(64)) - 32);
    return smrms_pkg::sample_t'($urandom());
  endfunction

  // Result checker: every accepted result must match the oldest owed one.
  always @(posedge clk_i) begin
    meter_reading_t owed;
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready) begin
      if (pending_readings.size() == 0) begin
        note_mismatch($sformatf("unexpected result rms=%0d level=%0d",
                                res_if.rms_level, res_if.smoothed_level));
      end else begin
        owed = pending_readings.pop_front();
        if (res_if.rms_level !== owed.rms)
          note_mismatch($sformatf("rms_level expected %0d got %0d",
                                  owed.rms, res_if.rms_level));
        if (res_if.smoothed_level !== owed.level)
          note_mismatch($sformatf("smoothed_level expected %0d got %0d",
                                  owed.level, res_if.smoothed_level));
      end
    end
  end

  // Result-side backpressure: random stalls per phase, plus the long hold.
  always @(posedge clk_i) begin
    res_if.ready <= !stall_hold &&
                    !(receiver_stall_pct != 0 && $urandom_range(99) < receiver_stall_pct);
  end

  // Long hold-off on the result side while requests keep coming, so the
  // meter backs up and has to refuse input for a while.
  initial begin
    stall_hold = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    while (!(accepted_pairs > 300 && res_if.valid === 1'b1)) @(posedge clk_i);
    stall_hold <= 1'b1;
    repeat (500) @(posedge clk_i);
    stall_hold <= 1'b0;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[smoothed_rms_level_meter_top] ERROR");
      $finish;
    end
  end

  // Main sequence: reset, directed rows, then five random phases that each
  // start with a new weight and set the sender idle and receiver stall rates for that phase.
  initial begin
    int unsigned sender_pcts [5];
    int unsigned receiver_pcts [5];
    int unsigned frame_len;
    int unsigned sent_in_phase;
    int unsigned sel;
    bit          drop_mark;
    logic [smrms_pkg::WEIGHT_W-1:0] phase_weight;

    sender_pcts   = '{0, 68, 0, 7, 0};
    receiver_pcts = '{0, 0, 68, 7, 0};

    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = '0;
    req_if.valid         = 1'b0;
    req_if.left_sample   = '0;
    req_if.right_sample  = '0;
    req_if.last_in_frame = 1'b0;
    res_if.ready         = 1'b0;
    mismatches           = 0;
    accepted_pairs       = 0;
    cycle_count          = 0;
    sender_idle_pct      = 0;
    receiver_stall_pct   = 0;
    sum_of_squares_q     = '0;
    pairs_in_frame_q     = 0;
    smoothed_q           = '0;
    keep_weight_q        = smrms_pkg::KEEP_WEIGHT_RST;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WEIGHT) begin
        write_keep_weight(directed_rows[i].weight[smrms_pkg::WEIGHT_W-1:0]);
      end else begin
        for (int k = 0; k < directed_rows[i].reps; k++) begin
          send_pair(smrms_pkg::sample_t'(directed_rows[i].left),
                    smrms_pkg::sample_t'(directed_rows[i].right),
                    directed_rows[i].last, directed_rows[i].typed,
                    smrms_pkg::rms_t'(directed_rows[i].rms),
                    smrms_pkg::level_t'(directed_rows[i].level));
        end
      end
    end

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: phase_weight = smrms_pkg::WEIGHT_W'($urandom_range(1, 255));
        1: phase_weight = '0;
        2: phase_weight = smrms_pkg::WEIGHT_W'($urandom_range(257, 511));
        3: phase_weight = smrms_pkg::WEIGHT_W'($urandom_range(0, 256));
        default: phase_weight = smrms_pkg::WEIGHT_FULL;
      endcase
      write_keep_weight(phase_weight);
      sender_idle_pct    = sender_pcts[ph];
      receiver_stall_pct = receiver_pcts[ph];

      // Whole frames of random length; a few drop their end mark and merge
      // into the next frame, and rare long ones run into the pair limit.
      sent_in_phase = 0;
      while (sent_in_phase < PAIRS_PER_PHASE) begin
        sel = $urandom_range(99);
        if (sel < 90)      frame_len = $urandom_range(1, 8);
        else if (sel < 98) frame_len = $urandom_range(9, 64);
        else               frame_len = $urandom_range(200, 300);
        drop_mark = ($urandom_range(99) < 8);
        for (int k = 0; k < frame_len; k++) begin
          send_pair(pick_sample(), pick_sample(), (k == frame_len - 1) && !drop_mark,
                    1'b0, '0, '0);
        end
        sent_in_phase += frame_len;
      end
    end

    req_if.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("[smoothed_rms_level_meter_top] OK");
    end else begin
      $display("[smoothed_rms_level_meter_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/smrms_pkg.sv
rtl/core/smrms_in_if.sv
rtl/core/smrms_out_if.sv
rtl/core/smoothed_rms_level_meter_top.sv
tb/tb_top.sv
